FILE: rtl/ctk_pkg.sv
// Shared types, token codes and character class helpers for the C subset tokenizer.
package ctk_pkg;

	localparam int unsigned POSITION_BITS_DEF = 16;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned KIND_W   = 6;
	localparam int unsigned VALUE_W  = 31;
	localparam int unsigned OFFS_W   = 16;
	localparam int unsigned NSKIP    = 4;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned Q_DEPTH  = 4;
	localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W  = Q_PTR_W + 1;

	localparam logic [VALUE_W-1:0] NUM_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_C = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_D = 2'd3;

	localparam logic [CHAR_W-1:0] SKIP_A_RST = 8'd32;
	localparam logic [CHAR_W-1:0] SKIP_B_RST = 8'd10;
	localparam logic [CHAR_W-1:0] SKIP_C_RST = 8'd9;
	localparam logic [CHAR_W-1:0] SKIP_D_RST = 8'd13;

	localparam logic [KIND_W-1:0] TK_LPAR      = 6'd0;
	localparam logic [KIND_W-1:0] TK_RPAR      = 6'd1;
	localparam logic [KIND_W-1:0] TK_LBRC      = 6'd2;
	localparam logic [KIND_W-1:0] TK_RBRC      = 6'd3;
	localparam logic [KIND_W-1:0] TK_SEMI      = 6'd4;
	localparam logic [KIND_W-1:0] TK_COMMA     = 6'd5;
	localparam logic [KIND_W-1:0] TK_TILDE     = 6'd6;
	localparam logic [KIND_W-1:0] TK_DEC       = 6'd7;
	localparam logic [KIND_W-1:0] TK_MINUS     = 6'd8;
	localparam logic [KIND_W-1:0] TK_PLUS      = 6'd9;
	localparam logic [KIND_W-1:0] TK_STAR      = 6'd10;
	localparam logic [KIND_W-1:0] TK_SLASH     = 6'd11;
	localparam logic [KIND_W-1:0] TK_PERCENT   = 6'd12;
	localparam logic [KIND_W-1:0] TK_LAND      = 6'd13;
	localparam logic [KIND_W-1:0] TK_BAND      = 6'd14;
	localparam logic [KIND_W-1:0] TK_LOR       = 6'd15;
	localparam logic [KIND_W-1:0] TK_BOR       = 6'd16;
	localparam logic [KIND_W-1:0] TK_BXOR      = 6'd17;
	localparam logic [KIND_W-1:0] TK_NE        = 6'd18;
	localparam logic [KIND_W-1:0] TK_LNOT      = 6'd19;
	localparam logic [KIND_W-1:0] TK_SHL       = 6'd20;
	localparam logic [KIND_W-1:0] TK_LE        = 6'd21;
	localparam logic [KIND_W-1:0] TK_SHR       = 6'd22;
	localparam logic [KIND_W-1:0] TK_GE        = 6'd23;
	localparam logic [KIND_W-1:0] TK_LT        = 6'd24;
	localparam logic [KIND_W-1:0] TK_GT        = 6'd25;
	localparam logic [KIND_W-1:0] TK_EQ        = 6'd26;
	localparam logic [KIND_W-1:0] TK_KW_INT    = 6'd27;
	localparam logic [KIND_W-1:0] TK_KW_RETURN = 6'd28;
	localparam logic [KIND_W-1:0] TK_NUMBER    = 6'd29;
	localparam logic [KIND_W-1:0] TK_STRING    = 6'd30;
	localparam logic [KIND_W-1:0] TK_NAME      = 6'd31;
	localparam logic [KIND_W-1:0] TK_EOF       = 6'd32;
	localparam logic [KIND_W-1:0] TK_ERROR     = 6'd33;
	localparam logic [KIND_W-1:0] TK_NONE      = 6'd63;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_OP,
		MODE_NUMBER,
		MODE_STRING,
		MODE_NAME
	} mode_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic               ovf;
		logic [OFFS_W-1:0]  start;
		logic [OFFS_W-1:0]  len;
		logic               last;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
		return c inside {["a":"z"], ["A":"Z"]};
	endfunction

	function automatic logic is_op_start(input logic [CHAR_W-1:0] c);
		return c inside {"-", "&", "|", "!", "<", ">", "="};
	endfunction

	function automatic logic [KIND_W-1:0] single_kind(input logic [CHAR_W-1:0] c);
		logic [KIND_W-1:0] k;
		case (c)
			"(": k = TK_LPAR;
			")": k = TK_RPAR;
			"{": k = TK_LBRC;
			"}": k = TK_RBRC;
			";": k = TK_SEMI;
			",": k = TK_COMMA;
			"~": k = TK_TILDE;
			"+": k = TK_PLUS;
			"*": k = TK_STAR;
			"/": k = TK_SLASH;
			"%": k = TK_PERCENT;
			"^": k = TK_BXOR;
			default: k = TK_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [KIND_W-1:0] pair_kind(input logic [CHAR_W-1:0] f,
		input logic [CHAR_W-1:0] c);
		logic [KIND_W-1:0] k;
		k = TK_NONE;
		case (f)
			"-": if (c == "-") k = TK_DEC;
			"&": if (c == "&") k = TK_LAND;
			"|": if (c == "|") k = TK_LOR;
			"!": if (c == "=") k = TK_NE;
			"<": begin
				if (c == "<") k = TK_SHL;
				else if (c == "=") k = TK_LE;
			end
			">": begin
				if (c == ">") k = TK_SHR;
				else if (c == "=") k = TK_GE;
			end
			"=": if (c == "=") k = TK_EQ;
			default: k = TK_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [KIND_W-1:0] lone_kind(input logic [CHAR_W-1:0] f);
		logic [KIND_W-1:0] k;
		case (f)
			"-": k = TK_MINUS;
			"&": k = TK_BAND;
			"|": k = TK_BOR;
			"!": k = TK_LNOT;
			"<": k = TK_LT;
			">": k = TK_GT;
			default: k = TK_ERROR;
		endcase
		return k;
	endfunction

	function automatic logic [3:0] word_len(input logic [CHAR_W-1:0] f);
		return (f == "i") ? 4'd3 : 4'd6;
	endfunction

	function automatic logic [CHAR_W-1:0] word_char(input logic [CHAR_W-1:0] f,
		input logic [3:0] k);
		logic [CHAR_W-1:0] w;
		if (f == "i") begin
			case (k[1:0])
				2'd0: w = "i";
				2'd1: w = "n";
				2'd2: w = "t";
				default: w = 8'd0;
			endcase
		end else begin
			case (k)
				4'd0: w = "r";
				4'd1: w = "e";
				4'd2: w = "t";
				4'd3: w = "u";
				4'd4: w = "r";
				4'd5: w = "n";
				default: w = 8'd0;
			endcase
		end
		return w;
	endfunction

endpackage

FILE: rtl/c_subset_tokenizer.sv
// Top level of the C subset tokenizer: skip-character registers, scanner and token queue.
// Flow: each byte is held in the scanner's input register and scanned combinationally;
//   its tokens go to the four-entry token queue, which offers them on the master side.
// Throughput: one byte per cycle while the queue has room for two tokens; a byte that
//   closes a token and is a one-byte token itself gives two, drained one per m_tready cycle.
// Reset: arst_n clears scan state, position and the queue at once; skip characters
//   return to 32, 10, 9 and 13.
module c_subset_tokenizer #(
	parameter int unsigned POSITION_BITS = ctk_pkg::POSITION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // char_byte
	input  logic                            s_tuser,   // end_marker
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [63:0]                     m_tdata,   // number_value, number_overflow,
	                                                   // start_offset, token_length
	output logic [ctk_pkg::KIND_W-1:0]      m_tuser,   // token_kind
	output logic                            m_tlast,   // last_of_run
	input  logic                            cfg_we,
	input  logic [ctk_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ctk_pkg::CHAR_W-1:0]      cfg_wdata
);

	logic [ctk_pkg::NSKIP-1:0][ctk_pkg::CHAR_W-1:0] skip_q;
	logic                                         room;
	ctk_pkg::push_t                               push;
	ctk_pkg::res_t                                head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q[0] <= ctk_pkg::SKIP_A_RST;
			skip_q[1] <= ctk_pkg::SKIP_B_RST;
			skip_q[2] <= ctk_pkg::SKIP_C_RST;
			skip_q[3] <= ctk_pkg::SKIP_D_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ctk_pkg::CFG_SKIP_A: skip_q[0] <= cfg_wdata;
				ctk_pkg::CFG_SKIP_B: skip_q[1] <= cfg_wdata;
				ctk_pkg::CFG_SKIP_C: skip_q[2] <= cfg_wdata;
				ctk_pkg::CFG_SKIP_D: skip_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ctk_scan #(
		.POSITION_BITS(POSITION_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_char  (s_tdata),
		.in_end   (s_tuser),
		.skip     (skip_q),
		.room     (room),
		.push     (push)
	);

	ctk_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (head)
	);

	assign m_tdata = {head.len, head.start, head.ovf, head.value};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule

FILE: rtl/ctk_scan.sv
// Input register and per-byte scan step: updates lexer state, produces up to two tokens.
module ctk_scan #(
	parameter int unsigned POSITION_BITS = ctk_pkg::POSITION_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         in_valid,
	output logic                                         in_ready,
	input  logic [ctk_pkg::CHAR_W-1:0]                   in_char,
	input  logic                                         in_end,
	input  logic [ctk_pkg::NSKIP-1:0][ctk_pkg::CHAR_W-1:0] skip,
	input  logic                                         room,
	output ctk_pkg::push_t                               push
);

	logic                          valid_s1;
	logic [ctk_pkg::CHAR_W-1:0]    char_s1;
	logic                          end_s1;
	logic                          adv;

	ctk_pkg::mode_t                mode_q, mode_d;
	logic [ctk_pkg::CHAR_W-1:0]    pf_q, pf_d;
	logic [3:0]                    kp_q, kp_d;
	logic [POSITION_BITS-1:0]      pos_q, pos_d;
	logic [POSITION_BITS-1:0]      ts_q, ts_d;
	logic [ctk_pkg::VALUE_W-1:0]   acc_q, acc_d;
	logic                          sat_q, sat_d;

	ctk_pkg::res_t                 fa, fb;
	logic                          fa_v, fb_v;

	assign adv      = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= in_char;
			end_s1  <= in_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ctk_pkg::MODE_IDLE;
			pf_q   <= '0;
			kp_q   <= '0;
			pos_q  <= '0;
			ts_q   <= '0;
			acc_q  <= '0;
			sat_q  <= 1'b0;
		end else if (adv) begin
			mode_q <= mode_d;
			pf_q   <= pf_d;
			kp_q   <= kp_d;
			pos_q  <= pos_d;
			ts_q   <= ts_d;
			acc_q  <= acc_d;
			sat_q  <= sat_d;
		end
	end

	always_comb begin
		logic [ctk_pkg::CHAR_W-1:0]  c;
		logic [POSITION_BITS-1:0]    len;
		logic [POSITION_BITS-1:0]    str_start;
		logic [POSITION_BITS-1:0]    str_len;
		logic [ctk_pkg::KIND_W-1:0]  pk;
		logic [ctk_pkg::KIND_W-1:0]  sk;
		logic [34:0]                 mac;
		logic [3:0]                  kp_inc;
		logic                        done;
		logic                        skip_hit;
		ctk_pkg::res_t               flush_r;
		logic                        flush_v;

		c         = char_s1;
		len       = pos_q - ts_q;
		str_start = ts_q + POSITION_BITS'(1);
		str_len   = pos_q - ts_q - POSITION_BITS'(1);
		pk        = ctk_pkg::pair_kind(pf_q, c);
		sk        = ctk_pkg::single_kind(c);
		mac       = 35'({acc_q, 3'b000}) + 35'({acc_q, 1'b0}) + 35'(c[3:0]);
		kp_inc    = kp_q + 4'd1;
		done      = 1'b0;
		skip_hit  = (c == skip[0]) || (c == skip[1]) || (c == skip[2]) || (c == skip[3]);

		mode_d = mode_q;
		pf_d   = pf_q;
		kp_d   = kp_q;
		pos_d  = pos_q;
		ts_d   = ts_q;
		acc_d  = acc_q;
		sat_d  = sat_q;
		fa     = '0;
		fb     = '0;
		fa_v   = 1'b0;
		fb_v   = 1'b0;

		// token in progress, closed at the current position
		flush_r       = '0;
		flush_r.start = 16'(ts_q);
		flush_r.len   = 16'(len);
		flush_v       = 1'b1;
		case (mode_q)
			ctk_pkg::MODE_OP: begin
				flush_r.kind = ctk_pkg::lone_kind(pf_q);
				flush_r.len  = 16'd1;
			end
			ctk_pkg::MODE_NUMBER: begin
				flush_r.kind  = ctk_pkg::TK_NUMBER;
				flush_r.value = acc_q;
				flush_r.ovf   = sat_q;
			end
			ctk_pkg::MODE_STRING: flush_r.kind = ctk_pkg::TK_ERROR;
			ctk_pkg::MODE_NAME:   flush_r.kind = ctk_pkg::TK_NAME;
			default:              flush_v = 1'b0;
		endcase

		if (end_s1) begin
			fa      = flush_r;
			fa_v    = flush_v;
			fb.kind = ctk_pkg::TK_EOF;
			fb.start = 16'(pos_q);
			fb_v    = 1'b1;
			mode_d  = ctk_pkg::MODE_IDLE;
			pf_d    = '0;
			kp_d    = '0;
			acc_d   = '0;
			sat_d   = 1'b0;
			pos_d   = '0;
			ts_d    = '0;
		end else begin
			case (mode_q)
				ctk_pkg::MODE_OP: begin
					if (pk != ctk_pkg::TK_NONE) begin
						fa.kind  = pk;
						fa.start = 16'(ts_q);
						fa.len   = 16'd2;
						done     = 1'b1;
					end else begin
						fa = flush_r;
					end
					fa_v = 1'b1;
				end
				ctk_pkg::MODE_NUMBER: begin
					if (ctk_pkg::is_digit(c)) begin
						if (mac > 35'(ctk_pkg::NUM_MAX)) begin
							acc_d = ctk_pkg::NUM_MAX;
							sat_d = 1'b1;
						end else begin
							acc_d = mac[ctk_pkg::VALUE_W-1:0];
						end
						done = 1'b1;
					end else begin
						fa   = flush_r;
						fa_v = 1'b1;
					end
				end
				ctk_pkg::MODE_STRING: begin
					if (c == "\"") begin
						fa.kind  = ctk_pkg::TK_STRING;
						fa.start = 16'(str_start);
						fa.len   = 16'(str_len);
						fa_v     = 1'b1;
					end
					done = 1'b1;
				end
				ctk_pkg::MODE_NAME: begin
					if (kp_q != 4'd0 && c == ctk_pkg::word_char(pf_q, kp_q)) begin
						kp_d = kp_inc;
						if (kp_inc >= ctk_pkg::word_len(pf_q)) begin
							fa.kind  = (pf_q == "i") ? ctk_pkg::TK_KW_INT
								: ctk_pkg::TK_KW_RETURN;
							fa.start = 16'(ts_q);
							fa.len   = 16'(ctk_pkg::word_len(pf_q));
							fa_v     = 1'b1;
						end
						done = 1'b1;
					end else if (ctk_pkg::is_alpha(c)) begin
						kp_d = '0;
						done = 1'b1;
					end else begin
						fa   = flush_r;
						fa_v = 1'b1;
					end
				end
				default: ;
			endcase

			// a closed token or a byte not taken returns the scanner to idle before any restart
			if (fa_v) begin
				mode_d = ctk_pkg::MODE_IDLE;
				pf_d   = '0;
				kp_d   = '0;
				acc_d  = '0;
				sat_d  = 1'b0;
			end else if (!done) begin
				mode_d = ctk_pkg::MODE_IDLE;
				pf_d   = '0;
				kp_d   = '0;
				acc_d  = '0;
				sat_d  = 1'b0;
			end

			if (!done && !skip_hit) begin
				if (sk != ctk_pkg::TK_NONE) begin
					fb.kind  = sk;
					fb.start = 16'(pos_q);
					fb.len   = 16'd1;
					fb_v     = 1'b1;
				end else begin
					ts_d = pos_q;
					if (ctk_pkg::is_op_start(c)) begin
						mode_d = ctk_pkg::MODE_OP;
						pf_d   = c;
					end else if (ctk_pkg::is_digit(c)) begin
						mode_d = ctk_pkg::MODE_NUMBER;
						acc_d  = ctk_pkg::VALUE_W'(c[3:0]);
						sat_d  = 1'b0;
					end else if (c == "\"") begin
						mode_d = ctk_pkg::MODE_STRING;
					end else if (ctk_pkg::is_alpha(c)) begin
						mode_d = ctk_pkg::MODE_NAME;
						if (c == "i" || c == "r") begin
							pf_d = c;
							kp_d = 4'd1;
						end else begin
							kp_d = '0;
						end
					end else begin
						fb.kind  = ctk_pkg::TK_ERROR;
						fb.start = 16'(pos_q);
						fb.len   = 16'd1;
						fb_v     = 1'b1;
					end
				end
			end
			pos_d = pos_q + POSITION_BITS'(1);
		end
	end

	always_comb begin
		push = '0;
		if (adv) begin
			if (fa_v) begin
				push.r0      = fa;
				push.r0.last = !fb_v;
				push.r1      = fb;
				push.r1.last = 1'b1;
				push.cnt     = fb_v ? 2'd2 : 2'd1;
			end else if (fb_v) begin
				push.r0      = fb;
				push.r0.last = 1'b1;
				push.cnt     = 2'd1;
			end
		end
	end

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && end_s1 |-> (push.cnt == 2'd1 && push.r0.kind == ctk_pkg::TK_EOF) ||
			(push.cnt == 2'd2 && push.r1.kind == ctk_pkg::TK_EOF))
		else $error("end marker did not close with end of file");

	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && end_s1 |=> pos_q == '0 && mode_q == ctk_pkg::MODE_IDLE)
		else $error("position not restarted after end of file");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd0 |-> room && valid_s1)
		else $error("tokens pushed without queue room");

endmodule

FILE: rtl/ctk_outq.sv
// Four-entry token queue: takes up to two tokens per cycle, hands out one per request.
module ctk_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  ctk_pkg::push_t push,
	output logic           room,
	output logic           out_valid,
	input  logic           out_ready,
	output ctk_pkg::res_t  out_res
);

	ctk_pkg::res_t                 mem_q [ctk_pkg::Q_DEPTH];
	logic [ctk_pkg::Q_PTR_W-1:0]   wp_q, rp_q;
	logic [ctk_pkg::Q_CNT_W-1:0]   cnt_q;
	logic                          pop;
	logic [ctk_pkg::Q_PTR_W-1:0]   wp_nx;

	assign room      = cnt_q <= ctk_pkg::Q_CNT_W'(ctk_pkg::Q_DEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign out_res   = mem_q[rp_q];
	assign pop       = out_valid && out_ready;
	assign wp_nx     = wp_q + ctk_pkg::Q_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) mem_q[wp_q] <= push.r0;
		if (push.cnt == 2'd2) mem_q[wp_nx] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + ctk_pkg::Q_PTR_W'(push.cnt);
			rp_q  <= rp_q + ctk_pkg::Q_PTR_W'(pop);
			cnt_q <= cnt_q + ctk_pkg::Q_CNT_W'(push.cnt) - ctk_pkg::Q_CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ctk_pkg::Q_CNT_W'(ctk_pkg::Q_DEPTH))
		else $error("token queue overflow");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd0 && pop |=> cnt_q == $past(cnt_q) - ctk_pkg::Q_CNT_W'(1))
		else $error("token queue count lost a request");

endmodule
